// ===== src/efb_pkg.sv =====
package efb_pkg;

  localparam int HDR_LEN     = 14;
  localparam int FCS_LEN     = 4;
  localparam int MIN_PAYLOAD = 46;
  localparam int COUNT_W     = 11;
  localparam int IDX_W       = 4;
  localparam int ADDR_W      = 48;
  localparam int TYPE_W      = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TYPE_W-1:0] TYPE_RESET = 16'h0800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST   = 2'd0,
    REG_SOURCE = 2'd1,
    REG_TYPE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_FCS
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] source_address;
    logic [TYPE_W-1:0] ether_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       short_payload;
  } out_t;

  // Reflected CRC-32, one byte folded in eight single-bit steps.
  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/efb_in_if.sv =====
interface efb_in_if
  import efb_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ===== src/efb_out_if.sv =====
interface efb_out_if
  import efb_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       short_payload;

  modport source (output valid, output frame_byte, output frame_end,
                  output short_payload, input ready);
  modport sink (input valid, input frame_byte, input frame_end,
                input short_payload, output ready);
endinterface

// ===== src/efb_cfg_if.sv =====
interface efb_cfg_if
  import efb_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/efb_regs.sv =====
module efb_regs
  import efb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  efb_cfg_if.sink cfg,
  output cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dest_address   <= '0;
      regs.source_address <= '0;
      regs.ether_type     <= TYPE_RESET;
    end else if (cfg.valid) begin
      // Writes beyond the last register are dropped.
      case (cfg.index)
        REG_DEST:   regs.dest_address   <= cfg.data;
        REG_SOURCE: regs.source_address <= cfg.data;
        REG_TYPE:   regs.ether_type     <= cfg.data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/efb_seq.sv =====
module efb_seq
  import efb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  efb_in_if.sink payload,
  input  cfg_t  regs,
  input  logic  load,
  output logic  emit,
  output out_t  emit_data
);

  logic                 item_valid;
  logic [7:0]           item_byte;
  logic                 item_last;
  phase_t               phase, phase_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [31:0]          crc, crc_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 adv;
  logic                 consume;
  logic [HDR_LEN*8-1:0] hdr;
  logic [6:0]           hdr_lsb;
  logic [31:0]          fcs;
  logic                 fcs_last;

  assign hdr     = {regs.dest_address, regs.source_address, regs.ether_type};
  assign hdr_lsb = {IDX_W'(HDR_LEN - 1) - idx, 3'b000};
  assign fcs     = ~crc;
  assign fcs_last = (idx == IDX_W'(FCS_LEN - 1));

  assign emit          = item_valid;
  assign adv           = item_valid && load;
  assign payload.ready = !item_valid || consume;

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    crc_next   = crc;
    count_next = count;
    consume    = 1'b0;
    emit_data  = '0;
    unique case (phase)
      PH_HEADER: begin
        emit_data.frame_byte = hdr[hdr_lsb +: 8];
        crc_next = crc_fold(crc, emit_data.frame_byte);
        if (idx == IDX_W'(HDR_LEN - 1)) begin
          phase_next = PH_PAYLOAD;
          idx_next   = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        emit_data.frame_byte = item_byte;
        crc_next = crc_fold(crc, item_byte);
        if (count != COUNT_MAX) begin
          count_next = count + 1'b1;
        end
        if (item_last) begin
          phase_next = PH_FCS;
        end else begin
          consume = adv;
        end
      end
      PH_FCS: begin
        emit_data.frame_byte    = fcs[{idx[1:0], 3'b000} +: 8];
        emit_data.frame_end     = fcs_last;
        emit_data.short_payload = fcs_last && (count < COUNT_W'(MIN_PAYLOAD));
        if (fcs_last) begin
          phase_next = PH_HEADER;
          idx_next   = '0;
          crc_next   = CRC_INIT;
          count_next = '0;
          consume    = adv;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      idx   <= '0;
      crc   <= CRC_INIT;
      count <= '0;
    end else if (adv) begin
      phase <= phase_next;
      idx   <= idx_next;
      crc   <= crc_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (payload.valid && payload.ready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (payload.valid && payload.ready) begin
      item_byte <= payload.payload_byte;
      item_last <= payload.last_byte;
    end
  end

endmodule

// ===== src/efb_obuf.sv =====
module efb_obuf
  import efb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  emit,
  input  out_t  emit_data,
  output logic  load,
  efb_out_if.source frame
);

  out_t data;

  assign load                = !frame.valid || frame.ready;
  assign frame.frame_byte    = data.frame_byte;
  assign frame.frame_end     = data.frame_end;
  assign frame.short_payload = data.short_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      data <= emit_data;
    end
  end

endmodule

// ===== src/ethernet_frame_builder.sv =====
// Ethernet frame builder with CRC-32 frame check sequence.
// Channels: payload takes one payload byte per request with last_byte marking
// the final byte of a frame; frame delivers the built frame one byte per
// request; cfg writes dest_address (index 0), source_address (index 1) and
// ether_type (index 2) and is always ready. Write cfg only between frames.
// The first payload byte of a frame emits the 14 header bytes ahead of it;
// the byte marked last is followed by the four FCS bytes, least significant
// first, with frame_end and short_payload (payload under 46 bytes) on the
// final FCS byte. Frames are not padded.
// A payload byte passes through the input register, then the output register.
// Throughput: one output byte per cycle while frame is ready; a frame's first
// payload byte adds the 14 header bytes and its last byte the four FCS bytes.
// The payload channel is not ready during a header or FCS burst, because the
// input register still holds the byte that started it; the next request is
// taken in the cycle that the last FCS byte moves into the output register.
// Reset clears the sequencer to await a new frame, empties both registers and
// restores the configuration defaults (ether_type 0x0800).
// When frame stalls, the output register holds its byte and the sequencer stops
// until it is taken; the payload channel fills only an empty input register.
module ethernet_frame_builder
  import efb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  efb_in_if.sink     payload,
  efb_out_if.source  frame,
  efb_cfg_if.sink    cfg
);

  cfg_t regs;
  logic load;
  logic emit;
  out_t emit_data;

  efb_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  efb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .payload   (payload),
    .regs      (regs),
    .load      (load),
    .emit      (emit),
    .emit_data (emit_data)
  );

  efb_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .emit_data (emit_data),
    .load      (load),
    .frame     (frame)
  );

`ifndef SYNTHESIS
  // Nothing is delivered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !frame.valid)
    else $error("frame valid right after reset");

  // The short flag only ever rides on the final FCS byte.
  a_short_on_end: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.short_payload |-> frame.frame_end)
    else $error("short_payload outside final FCS byte");

  // A frame is at least 19 bytes, so two frame ends never come back to back.
  a_end_spacing: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready && frame.frame_end |=> !(frame.valid && frame.frame_end))
    else $error("consecutive frame_end bytes");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import efb_pkg::*;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_ITEMS = 330;
  localparam int LONG_FRAME   = 2060;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pay_req_t;

  logic clk;
  logic rst;

  efb_in_if  payload ();
  efb_out_if frame ();
  efb_cfg_if cfg ();

  ethernet_frame_builder dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .frame   (frame),
    .cfg     (cfg)
  );

  pay_req_t pay_pending[$];
  out_t     frame_bytes_due[$];

  // Shadow of the block's registers and frame state.
  cfg_t               cfg_shadow;
  logic [31:0]        fcs_acc;
  logic [COUNT_W-1:0] pay_count;
  logic               fr_open;

  int  mismatches;
  int  queued_items;
  int  cycle_count;
  bit  in_steady;
  bit  out_steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
               frame_bytes_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Most gaps are short, a few are long; steady mode disables them.
  function automatic int pick_idle(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0] ^ b[k]}});
    end
    return r;
  endfunction

  function automatic void push_data(input logic [7:0] b);
    fcs_acc = crc_next(fcs_acc, b);
    frame_bytes_due.push_back('{frame_byte: b, frame_end: 1'b0, short_payload: 1'b0});
  endfunction

  // Expected frame bytes caused by one accepted payload request.
  function automatic void predict_frame(input logic [7:0] b, input logic last);
    logic [31:0] fcs;
    if (!fr_open) begin
      fcs_acc   = CRC_INIT;
      pay_count = '0;
      for (int i = 5; i >= 0; i--) push_data(cfg_shadow.dest_address[8*i +: 8]);
      for (int i = 5; i >= 0; i--) push_data(cfg_shadow.source_address[8*i +: 8]);
      push_data(cfg_shadow.ether_type[15:8]);
      push_data(cfg_shadow.ether_type[7:0]);
      fr_open = 1'b1;
    end
    push_data(b);
    if (pay_count != COUNT_MAX) pay_count++;
    if (last) begin
      fcs = ~fcs_acc;
      for (int i = 0; i < FCS_LEN; i++) begin
        frame_bytes_due.push_back('{frame_byte: fcs[8*i +: 8],
                                    frame_end: (i == FCS_LEN - 1),
                                    short_payload: (i == FCS_LEN - 1) &&
                                                   (pay_count < MIN_PAYLOAD)});
      end
      fcs_acc   = CRC_INIT;
      pay_count = '0;
      fr_open   = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : drive_payload
    int       gap_left;
    pay_req_t nxt;
    if (rst) begin
      payload.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (payload.valid && payload.ready) predict_frame(payload.payload_byte, payload.last_byte);
      if (!payload.valid || payload.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          payload.valid <= 1'b0;
        end else if (pay_pending.size() != 0) begin
          nxt = pay_pending.pop_front();
          payload.valid        <= 1'b1;
          payload.payload_byte <= nxt.data;
          payload.last_byte    <= nxt.last;
          gap_left = pick_idle(in_steady);
        end else begin
          payload.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_frame
    int   hold_left;
    out_t got;
    out_t want;
    if (rst) begin
      frame.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (frame.valid && frame.ready) begin
        got = '{frame_byte: frame.frame_byte, frame_end: frame.frame_end,
                short_payload: frame.short_payload};
        if (frame_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected frame byte %02h", got.frame_byte));
        end else begin
          want = frame_bytes_due.pop_front();
          if (got.frame_byte !== want.frame_byte)
            flag_mismatch($sformatf("frame_byte %02h, want %02h", got.frame_byte,
                                    want.frame_byte));
          if (got.frame_end !== want.frame_end)
            flag_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
          if (got.short_payload !== want.short_payload)
            flag_mismatch($sformatf("short_payload %b, want %b", got.short_payload,
                                    want.short_payload));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        frame.ready <= 1'b0;
      end else begin
        frame.ready <= 1'b1;
        hold_left = pick_idle(out_steady);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_DEST:   cfg_shadow.dest_address = value;
      REG_SOURCE: cfg_shadow.source_address = value;
      REG_TYPE:   cfg_shadow.ether_type = value[TYPE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] pick_reg_value();
    int r;
    r = $urandom_range(3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(1, 8);
    if (r < 60) return $urandom_range(9, 44);
    if (r < 80) return $urandom_range(45, 47);
    return $urandom_range(48, 70);
  endfunction

  function automatic void push_req(input logic [7:0] data, input logic last);
    pay_pending.push_back('{data: data, last: last});
    queued_items++;
  endfunction

  function automatic void queue_bytes(input int n, input bit closes);
    for (int i = 0; i < n; i++) push_req(8'($urandom()), closes && (i == n - 1));
  endfunction

  // Drained means every request is in and every expected byte is out; the
  // trailing wait covers the input and output registers.
  task automatic wait_idle();
    do @(negedge clk);
    while (pay_pending.size() != 0 || payload.valid || frame_bytes_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int len;
    int head;
    int nfr;
    int tail_left;

    rst                  = 1'b1;
    payload.valid        = 1'b0;
    payload.payload_byte = '0;
    payload.last_byte    = 1'b0;
    frame.ready          = 1'b0;
    cfg.valid            = 1'b0;
    cfg.index            = REG_DEST;
    cfg.data             = '0;
    cfg_shadow           = '{dest_address: '0, source_address: '0, ether_type: TYPE_RESET};
    fcs_acc              = CRC_INIT;
    pay_count            = '0;
    fr_open              = 1'b0;
    mismatches           = 0;
    queued_items         = 0;
    cycle_count          = 0;
    in_steady            = 1'b0;
    out_steady           = 1'b0;
    tail_left            = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Single-byte frames under the reset defaults and then at the extremes.
    push_req(8'h00, 1'b1);
    wait_idle();
    write_reg(REG_DEST, '1);
    write_reg(REG_SOURCE, '0);
    write_reg(REG_TYPE, {32'hA5A5_5A5A, 16'hFFFF});
    push_req(8'hFF, 1'b1);
    wait_idle();
    write_reg(REG_DEST, '0);
    write_reg(REG_SOURCE, '1);
    write_reg(REG_TYPE, '0);

    // A write in the middle of a frame only shows in the next header.
    push_req(8'h55, 1'b0);
    push_req(8'hAA, 1'b0);
    wait_idle();
    write_reg(REG_DEST, 48'h0123_4567_89AB);
    push_req(8'h3C, 1'b1);
    push_req(8'h81, 1'b0);
    push_req(8'h7E, 1'b1);
    wait_idle();

    while (queued_items < RANDOM_ITEMS) begin
      if ($urandom_range(1)) write_reg(REG_DEST, pick_reg_value());
      if ($urandom_range(1)) write_reg(REG_SOURCE, pick_reg_value());
      if ($urandom_range(1)) write_reg(REG_TYPE, pick_reg_value());
      in_steady  = ($urandom_range(3) == 0);
      out_steady = ($urandom_range(3) == 0);
      if (tail_left > 0) begin
        queue_bytes(tail_left, 1'b1);
        tail_left = 0;
      end
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        len = pick_len();
        if (f == nfr - 1 && len > 1 && $urandom_range(4) == 0) begin
          head = $urandom_range(1, len - 1);
          queue_bytes(head, 1'b0);
          tail_left = len - head;
        end else begin
          queue_bytes(len, 1'b1);
        end
      end
      wait_idle();
    end
    if (tail_left > 0) begin
      queue_bytes(tail_left, 1'b1);
      wait_idle();
    end

    // Past 2047 bytes the count must hold at its ceiling rather than wrap
    // back under the minimum length.
    write_reg(REG_TYPE, pick_reg_value());
    in_steady  = 1'b1;
    out_steady = 1'b0;
    queue_bytes(LONG_FRAME, 1'b1);
    wait_idle();
    in_steady = 1'b0;
    push_req(8'($urandom()), 1'b1);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
